// ===== rtl/core/mfa_pkg.sv =====
// Shared types, codes and constants of the mixed fraction arithmetic unit.
package mfa_pkg;

    localparam int MFA_OPERAND_WIDTH = 16;
    localparam int MFA_FIELD_WIDTH   = 16;
    localparam int MFA_DATA_WIDTH    = 64;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_ADD = 2'd2,
        OP_CMP = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [15:0] a_whole;
        logic signed [15:0] a_num;
        logic signed [15:0] a_den;
        logic signed [15:0] b_whole;
        logic signed [15:0] b_num;
        logic signed [15:0] b_den;
    } t_req;

    typedef struct packed {
        logic signed [63:0] res_whole;
        logic signed [63:0] res_num;
        logic signed [63:0] res_den;
        logic               is_equal;
        logic               is_greater;
        logic               is_less;
    } t_rsp;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        MS_AW_AD,
        MS_BW_BD,
        MS_AN_BN,
        MS_AD_BD,
        MS_AN_BD,
        MS_AD_BN,
        MS_BN_AD
    } t_msel;

    // multiplier result destinations
    typedef enum logic [2:0] {
        MD_AN,
        MD_BN,
        MD_P0,
        MD_P0_ADD,
        MD_P1
    } t_mdst;

    // divider operand sets
    typedef enum logic [1:0] {
        DS_PROD,
        DS_NUM,
        DS_DEN
    } t_dsel;

    typedef struct packed {
        logic  load;
        logic  mul_start;
        t_msel mul_sel;
        t_mdst mul_dst;
        logic  fix_den;
        logic  div_start;
        t_dsel div_sel;
        logic  gcd_start;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic gcd_done;
        logic rem_zero;
        logic gcd_one;
        logic out_free;
        t_op  op;
    } t_status;

endpackage

// ===== rtl/core/mfa_ctrl.sv =====
// Sequencer that steps the datapath through one request.
module mfa_ctrl
    import mfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_PA, S_PA_W,
        S_PB, S_PB_W,
        S_P0, S_P0_W,
        S_P1, S_P1_W,
        S_P2, S_P2_W,
        S_FIX,
        S_DIV, S_DIV_W,
        S_CHK,
        S_GCD, S_GCD_W,
        S_DN, S_DN_W,
        S_DD, S_DD_W,
        S_OUT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_PA;
                S_PA:    r_state <= S_PA_W;
                S_PA_W:  if (i_status.mul_done) r_state <= S_PB;
                S_PB:    r_state <= S_PB_W;
                S_PB_W:  if (i_status.mul_done) r_state <= S_P0;
                S_P0:    r_state <= S_P0_W;
                S_P0_W:  if (i_status.mul_done) r_state <= S_P1;
                S_P1:    r_state <= S_P1_W;
                S_P1_W: begin
                    if (i_status.mul_done) begin
                        if (i_status.op == OP_ADD)      r_state <= S_P2;
                        else if (i_status.op == OP_CMP) r_state <= S_OUT;
                        else                            r_state <= S_FIX;
                    end
                end
                S_P2:    r_state <= S_P2_W;
                S_P2_W:  if (i_status.mul_done) r_state <= S_FIX;
                S_FIX:   r_state <= (i_status.op == OP_ADD) ? S_OUT : S_DIV;
                S_DIV:   r_state <= S_DIV_W;
                S_DIV_W: if (i_status.div_done) r_state <= S_CHK;
                S_CHK:   r_state <= i_status.rem_zero ? S_OUT : S_GCD;
                S_GCD:   r_state <= S_GCD_W;
                S_GCD_W: begin
                    if (i_status.gcd_done) r_state <= i_status.gcd_one ? S_OUT : S_DN;
                end
                S_DN:    r_state <= S_DN_W;
                S_DN_W:  if (i_status.div_done) r_state <= S_DD;
                S_DD:    r_state <= S_DD_W;
                S_DD_W:  if (i_status.div_done) r_state <= S_OUT;
                S_OUT:   if (i_status.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MS_AW_AD;
        o_cmd.mul_dst = MD_AN;
        o_cmd.div_sel = DS_PROD;
        unique case (r_state)
            S_IDLE: o_cmd.load = i_valid;
            S_PA: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_AW_AD;
                o_cmd.mul_dst   = MD_AN;
            end
            S_PB: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_BW_BD;
                o_cmd.mul_dst   = MD_BN;
            end
            S_P0: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = (i_status.op == OP_MUL) ? MS_AN_BN : MS_AN_BD;
                o_cmd.mul_dst   = MD_P0;
            end
            S_P1: begin
                o_cmd.mul_start = 1'b1;
                unique case (i_status.op)
                    OP_MUL: begin
                        o_cmd.mul_sel = MS_AD_BD;
                        o_cmd.mul_dst = MD_P1;
                    end
                    OP_DIV: begin
                        o_cmd.mul_sel = MS_AD_BN;
                        o_cmd.mul_dst = MD_P1;
                    end
                    OP_ADD: begin
                        o_cmd.mul_sel = MS_BN_AD;
                        o_cmd.mul_dst = MD_P0_ADD;
                    end
                    default: begin
                        o_cmd.mul_sel = MS_BN_AD;
                        o_cmd.mul_dst = MD_P1;
                    end
                endcase
            end
            S_P2: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_AD_BD;
                o_cmd.mul_dst   = MD_P1;
            end
            S_FIX: o_cmd.fix_den = 1'b1;
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_PROD;
            end
            S_GCD: o_cmd.gcd_start = 1'b1;
            S_DN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_NUM;
            end
            S_DD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_DEN;
            end
            S_OUT: o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/mfa_datapath.sv =====
// Operand registers, shared multiplier, divider, GCD unit and result register.
module mfa_datapath
    import mfa_pkg::*;
#(
    parameter int OPERAND_WIDTH = MFA_OPERAND_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_req    i_req,
    input  logic    i_stall,
    output t_status o_status,
    output logic    o_valid,
    output t_rsp    o_rsp
);

    localparam int DW    = MFA_DATA_WIDTH;
    localparam int UW    = (OPERAND_WIDTH < MFA_FIELD_WIDTH) ? OPERAND_WIDTH : MFA_FIELD_WIDTH;
    localparam bit SX    = (OPERAND_WIDTH <= MFA_FIELD_WIDTH);
    localparam int DIGIT = 8;
    localparam int MSTEP = DW / DIGIT;
    localparam int MCW   = $clog2(MSTEP);
    localparam int DCW   = $clog2(DW);

    // a width above the field width zero-extends the field instead of sign-extending it
    function automatic logic [DW-1:0] sext(input logic [MFA_FIELD_WIDTH-1:0] v);
        return {{(DW-UW){SX & v[UW-1]}}, v[UW-1:0]};
    endfunction

    function automatic logic [DW-1:0] fix1(input logic [DW-1:0] v);
        return (v == '0) ? DW'(1) : v;
    endfunction

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
        return v[DW-1] ? -v : v;
    endfunction

    // operands and products
    t_op           r_op;
    logic [DW-1:0] r_wa, r_wb, r_an, r_bn, r_ad, r_bd, r_p0, r_p1;
    logic [DW-1:0] r_rw, r_rn, r_rd, r_g;

    // multiplier
    logic [DW-1:0]       r_mx, r_my, r_macc;
    logic [MCW-1:0]      r_mcnt;
    logic                r_mbusy, r_mdone;
    t_mdst               r_mdst;
    logic [DW-1:0]       m_x, m_y, m_acc_n;
    logic [DW+DIGIT-1:0] m_pp;

    // divider
    logic [DW-1:0]  r_dq, r_drem, r_dd;
    logic [DCW-1:0] r_dcnt;
    logic           r_dbusy, r_ddone;
    t_dsel          r_dsel;
    logic [DW-1:0]  d_n, d_d, d_rem_n, d_q_n;
    logic [DW:0]    d_t, d_diff;
    logic           d_ge;

    // gcd
    logic [DW-1:0]  r_gx, r_gy;
    logic [DCW-1:0] r_gk;
    logic           r_gbusy, r_gdone;

    logic r_ovalid;
    t_rsp r_rsp;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_AW_AD: begin m_x = r_wa; m_y = r_ad; end
            MS_BW_BD: begin m_x = r_wb; m_y = r_bd; end
            MS_AN_BN: begin m_x = r_an; m_y = r_bn; end
            MS_AD_BD: begin m_x = r_ad; m_y = r_bd; end
            MS_AN_BD: begin m_x = r_an; m_y = r_bd; end
            MS_AD_BN: begin m_x = r_ad; m_y = r_bn; end
            default:  begin m_x = r_bn; m_y = r_ad; end
        endcase
    end

    assign m_pp    = r_mx * r_my[DIGIT-1:0];
    assign m_acc_n = r_macc + m_pp[DW-1:0];

    always_comb begin
        case (i_cmd.div_sel)
            DS_PROD: begin d_n = mag(r_p0); d_d = mag(r_p1); end
            DS_NUM:  begin d_n = mag(r_rn); d_d = r_g;       end
            default: begin d_n = mag(r_rd); d_d = r_g;       end
        endcase
    end

    assign d_t     = {r_drem, r_dq[DW-1]};
    assign d_diff  = d_t - {1'b0, r_dd};
    assign d_ge    = (d_t >= {1'b0, r_dd});
    assign d_rem_n = d_ge ? d_diff[DW-1:0] : d_t[DW-1:0];
    assign d_q_n   = {r_dq[DW-2:0], d_ge};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy  <= 1'b0;
            r_mdone  <= 1'b0;
            r_mcnt   <= '0;
            r_dbusy  <= 1'b0;
            r_ddone  <= 1'b0;
            r_dcnt   <= '0;
            r_gbusy  <= 1'b0;
            r_gdone  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            r_ddone <= 1'b0;
            r_gdone <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 1'b1;
                if (r_mcnt == MCW'(MSTEP - 1)) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == DCW'(DW - 1)) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
            if (i_cmd.gcd_start) begin
                r_gbusy <= 1'b1;
            end else if (r_gbusy && (r_gx == '0 || r_gy == '0)) begin
                r_gbusy <= 1'b0;
                r_gdone <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_req.op;
            r_wa <= sext(i_req.a_whole);
            r_an <= sext(i_req.a_num);
            r_ad <= fix1(sext(i_req.a_den));
            r_wb <= sext(i_req.b_whole);
            r_bn <= sext(i_req.b_num);
            r_bd <= fix1(sext(i_req.b_den));
        end

        // shift-add multiply, one byte of the multiplier per cycle
        if (i_cmd.mul_start) begin
            r_mx   <= m_x;
            r_my   <= m_y;
            r_macc <= '0;
            r_mdst <= i_cmd.mul_dst;
        end else if (r_mbusy) begin
            r_mx   <= r_mx << DIGIT;
            r_my   <= r_my >> DIGIT;
            r_macc <= m_acc_n;
            if (r_mcnt == MCW'(MSTEP - 1)) begin
                case (r_mdst)
                    MD_AN:     r_an <= r_an + m_acc_n;
                    MD_BN:     r_bn <= r_bn + m_acc_n;
                    MD_P0:     r_p0 <= m_acc_n;
                    MD_P0_ADD: r_p0 <= r_p0 + m_acc_n;
                    default:   r_p1 <= m_acc_n;
                endcase
            end
        end

        if (i_cmd.fix_den) begin
            r_p1 <= fix1(r_p1);
        end

        // restoring division on magnitudes, one quotient bit per cycle
        if (i_cmd.div_start) begin
            r_dq   <= d_n;
            r_dd   <= d_d;
            r_drem <= '0;
            r_dsel <= i_cmd.div_sel;
        end else if (r_dbusy) begin
            r_dq   <= d_q_n;
            r_drem <= d_rem_n;
            if (r_dcnt == DCW'(DW - 1)) begin
                case (r_dsel)
                    DS_PROD: begin
                        r_rw <= (r_p0[DW-1] ^ r_p1[DW-1]) ? -d_q_n : d_q_n;
                        r_rn <= r_p0[DW-1] ? -d_rem_n : d_rem_n;
                        r_rd <= r_p1;
                    end
                    DS_NUM:  r_rn <= r_rn[DW-1] ? -d_q_n : d_q_n;
                    default: r_rd <= r_rd[DW-1] ? -d_q_n : d_q_n;
                endcase
            end
        end

        // binary GCD, one step per cycle
        if (i_cmd.gcd_start) begin
            r_gx <= mag(r_rn);
            r_gy <= mag(r_rd);
            r_gk <= '0;
        end else if (r_gbusy) begin
            if (r_gx == '0) begin
                r_g <= r_gy << r_gk;
            end else if (r_gy == '0) begin
                r_g <= r_gx << r_gk;
            end else if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_gk <= r_gk + 1'b1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gy - r_gx;
            end
        end

        if (i_cmd.out_load) begin
            r_rsp.is_equal   <= 1'b0;
            r_rsp.is_greater <= 1'b0;
            r_rsp.is_less    <= 1'b0;
            case (r_op)
                OP_MUL, OP_DIV: begin
                    r_rsp.res_whole <= r_rw;
                    r_rsp.res_num   <= r_rn;
                    r_rsp.res_den   <= r_rd;
                end
                OP_ADD: begin
                    r_rsp.res_whole <= '0;
                    r_rsp.res_num   <= r_p0;
                    r_rsp.res_den   <= r_p1;
                end
                default: begin
                    r_rsp.res_whole  <= '0;
                    r_rsp.res_num    <= '0;
                    r_rsp.res_den    <= DW'(1);
                    r_rsp.is_equal   <= (r_p0 == r_p1);
                    r_rsp.is_greater <= ($signed(r_p0) > $signed(r_p1));
                    r_rsp.is_less    <= ($signed(r_p0) < $signed(r_p1));
                end
            endcase
        end
    end

    assign o_status.mul_done = r_mdone;
    assign o_status.div_done = r_ddone;
    assign o_status.gcd_done = r_gdone;
    assign o_status.rem_zero = (r_rn == '0);
    assign o_status.gcd_one  = (r_g == DW'(1));
    assign o_status.out_free = !r_ovalid || !i_stall;
    assign o_status.op       = r_op;

    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

endmodule

// ===== rtl/core/mixed_fraction_arithmetic_unit_top.sv =====
// Top level of the mixed fraction arithmetic unit: sequencer plus datapath.
//
// Usage: a request (i_req) carries an operation and two mixed fractions
// (whole, numerator, denominator; a zero denominator counts as one). It is
// taken at a rising edge with i_valid high and o_stall low. The response
// (o_rsp) is offered with o_valid and taken at an edge with i_stall low.
//
// Flow: one request is worked on at a time. Each product goes through a
// shared shift-add multiplier, one byte per cycle. Compare and add end
// once their products are formed. Multiply and divide add a restoring
// division and, when the remainder is nonzero, a binary GCD; unless the
// GCD is one, two more divisions then reduce numerator and denominator.
//
// The result register parts the two sides: a new request is taken while a
// finished response still waits; a stalled response holds until taken, and
// the next response waits behind it. Reset returns the sequencer to idle and
// drops any pending response.
module mixed_fraction_arithmetic_unit_top
    import mfa_pkg::*;
#(
    parameter int OPERAND_WIDTH = MFA_OPERAND_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    mfa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mfa_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .i_stall  (i_stall),
        .o_status (status),
        .o_valid  (o_valid),
        .o_rsp    (o_rsp)
    );

endmodule

// ===== sim/mixed_fraction_arithmetic_unit_top_tb.sv =====
// Testbench of the mixed fraction arithmetic unit: directed and random requests checked live.
`timescale 1ns / 1ps

module mixed_fraction_arithmetic_unit_top_tb;
    import mfa_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_rsp;

    mixed_fraction_arithmetic_unit_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp  (o_rsp)
    );

    always #2 i_clk = ~i_clk;

    // Expected responses, oldest first.
    t_rsp expected_rsps[$];
    int   error_count = 0;
    int   sent_count = 0;
    int   checked_count = 0;
    int   op_count[4] = '{0, 0, 0, 0};

    // Idle controls: percent of cycles the sender idles and the receiver stalls.
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_off_cycles = 0;

    // Magnitude of a signed 64-bit value, as unsigned.
    function automatic logic [63:0] magnitude(logic signed [63:0] x);
        return x < 0 ? 64'd0 - x : x;
    endfunction

    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Truncating division that wraps on a divisor of minus one.
    function automatic logic signed [63:0] trunc_div(logic signed [63:0] n,
                                                     logic signed [63:0] d);
        if (d == -64'sd1) return 64'sd0 - n;
        return n / d;
    endfunction

    function automatic logic signed [63:0] trunc_rem(logic signed [63:0] n,
                                                     logic signed [63:0] d);
        if (d == -64'sd1) return 64'sd0;
        return n % d;
    endfunction

    // Compute the response of one request.
    function automatic t_rsp fraction_result(t_req r);
        t_rsp o;
        logic signed [63:0] ad, bd, an, bn, pn, pd, l, rt;
        logic [63:0] g;
        o = '0;
        o.res_den = 64'sd1;
        ad = (r.a_den == 0) ? 64'sd1 : 64'(r.a_den);
        bd = (r.b_den == 0) ? 64'sd1 : 64'(r.b_den);
        an = 64'(r.a_num) + 64'(r.a_whole) * ad;
        bn = 64'(r.b_num) + 64'(r.b_whole) * bd;
        case (r.op)
            OP_MUL, OP_DIV: begin
                if (r.op == OP_MUL) begin
                    pn = an * bn;
                    pd = ad * bd;
                end else begin
                    pn = an * bd;
                    pd = ad * bn;
                end
                if (pd == 0) pd = 64'sd1;
                o.res_whole = trunc_div(pn, pd);
                o.res_num = trunc_rem(pn, pd);
                o.res_den = pd;
                if (o.res_num != 0) begin
                    g = euclid_gcd(magnitude(o.res_num), magnitude(pd));
                    if (g > 1) begin
                        o.res_num = o.res_num / $signed(g);
                        o.res_den = o.res_den / $signed(g);
                    end
                end
            end
            OP_ADD: begin
                o.res_num = an * bd + bn * ad;
                o.res_den = ad * bd;
                if (o.res_den == 0) o.res_den = 64'sd1;
            end
            default: begin
                l = an * bd;
                rt = bn * ad;
                o.is_equal = (l == rt);
                o.is_greater = (l > rt);
                o.is_less = (l < rt);
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on response %0d: %s got %0h want %0h", checked_count, what, got,
                 want);
        error_count++;
    endtask

    // Drive the receiver stall: random stalls, or a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check each accepted response against the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected response", '0, '0);
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.res_whole !== want.res_whole)
                    report_mismatch("res_whole", o_rsp.res_whole, want.res_whole);
                if (o_rsp.res_num !== want.res_num)
                    report_mismatch("res_num", o_rsp.res_num, want.res_num);
                if (o_rsp.res_den !== want.res_den)
                    report_mismatch("res_den", o_rsp.res_den, want.res_den);
                if (o_rsp.is_equal !== want.is_equal)
                    report_mismatch("is_equal", o_rsp.is_equal, want.is_equal);
                if (o_rsp.is_greater !== want.is_greater)
                    report_mismatch("is_greater", o_rsp.is_greater, want.is_greater);
                if (o_rsp.is_less !== want.is_less)
                    report_mismatch("is_less", o_rsp.is_less, want.is_less);
            end
            checked_count++;
        end
    end

    // Optionally idle first, then offer one request and hold it until taken.
    // Valid stays high on return; the next send or a drain replaces it in this step.
    task automatic send_request(t_req r);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_rsps.push_back(fraction_result(r));
        op_count[r.op]++;
        sent_count++;
    endtask

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            4: return 16'($signed($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req make_req(t_op op, int a_w, int a_n, int a_d, int b_w, int b_n,
                                      int b_d);
        t_req r;
        r.op = op;
        r.a_whole = 16'(a_w);
        r.a_num = 16'(a_n);
        r.a_den = 16'(a_d);
        r.b_whole = 16'(b_w);
        r.b_num = 16'(b_n);
        r.b_den = 16'(b_d);
        return r;
    endfunction

    // Drop valid and wait until every expected response has been taken.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Extremes, each operation, zero denominators, zero remainder, negative denominators.
    task automatic test_directed();
        t_op op;
        for (int k = 0; k < 4; k++) begin
            op = t_op'(k);
            send_request(make_req(op, 1, 1, 2, 2, 1, 3));
            send_request(make_req(op, -32768, -32768, -32768, -32768, -32768, -32768));
            send_request(make_req(op, 32767, 32767, 32767, 32767, 32767, 32767));
            send_request(make_req(op, 3, 1, 0, 0, 5, 0));
            send_request(make_req(op, 0, 1, -3, 1, -1, 7));
        end
        // Divide by a zero value.
        send_request(make_req(OP_DIV, 1, 1, 2, 0, 0, 5));
        // Zero remainder: 3/2 * 2/3.
        send_request(make_req(OP_MUL, 1, 1, 2, 0, 2, 3));
        // Equal values, different forms.
        send_request(make_req(OP_CMP, 0, 1, 2, 0, 2, 4));
        drain();
    endtask

    // Random requests under one idle setting.
    task automatic test_random(int count, int send_pct, int recv_pct);
        t_req r;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            r.op = t_op'($urandom_range(3));
            r.a_whole = rand_field();
            r.a_num = rand_field();
            r.a_den = rand_field();
            r.b_whole = rand_field();
            r.b_num = rand_field();
            r.b_den = rand_field();
            send_request(r);
        end
        drain();
    endtask

    // Hold the receiver off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 3000;
        for (int n = 0; n < 20; n++)
            send_request(make_req(t_op'(n % 4), n, n + 1, n + 2, -n, 3, n - 5));
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(350, 0, 0);
        test_random(350, 70, 0);
        test_random(350, 0, 70);
        test_random(350, 23, 23);
        recv_stall_pct = 0;
        repeat (500) @(posedge i_clk);
        $display("covered %0d requests: mul %0d, div %0d, add %0d, cmp %0d", sent_count,
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("with idle and stall phases and one long receiver hold-off");
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Generous time limit on the whole run.
    initial begin
        #20ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
